FILE: rtl/rtm_pkg.sv
// Shared types and constants of the RGB tolerance match table.
package rtm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CHAN_W      = 16;
  localparam int OUT_IDX_W   = 4;

  localparam logic [CHAN_W-1:0] TOL_RESET = 16'd10;

  localparam int APB_REG_IDX_W = 1;
  localparam int APB_ADDR_W    = APB_REG_IDX_W + 2;
  localparam int APB_DATA_W    = 32;
  localparam logic [APB_REG_IDX_W-1:0] REG_TOLERANCE = 1'b0;

  typedef enum logic [1:0] {
    STATUS_IDENTIFIED   = 2'd0,
    STATUS_UNIDENTIFIED = 2'd1,
    STATUS_REGISTERED   = 2'd2,
    STATUS_FULL         = 2'd3
  } status_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

endpackage

FILE: rtl/rtm_if.sv
// Valid/ready channel interfaces for the input items and the result items.
interface rtm_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [rtm_pkg::CHAN_W-1:0] red;
  logic [rtm_pkg::CHAN_W-1:0] green;
  logic [rtm_pkg::CHAN_W-1:0] blue;

  modport source (output valid, output action, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input action, input red, input green, input blue,
                  output ready);
endinterface

interface rtm_rsp_if;
  logic                         valid;
  logic                         ready;
  rtm_pkg::status_e             status;
  logic [rtm_pkg::OUT_IDX_W-1:0] entry_index;

  modport source (output valid, output status, output entry_index, input ready);
  modport sink   (input valid, input status, input entry_index, output ready);
endinterface

FILE: rtl/rtm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rtm_match.sv
// Tolerance compare unit: checks one stored colour against the measured one.
module rtm_match (
  input  rtm_pkg::rgb_t              meas_i,
  input  rtm_pkg::rgb_t              entry_i,
  input  logic [rtm_pkg::CHAN_W-1:0] tol_i,
  output logic                       match_o
);

  logic [rtm_pkg::CHAN_W-1:0] diff_r;
  logic [rtm_pkg::CHAN_W-1:0] diff_g;
  logic [rtm_pkg::CHAN_W-1:0] diff_b;

  always_comb begin
    diff_r = (meas_i.red >= entry_i.red) ? (meas_i.red - entry_i.red)
                                         : (entry_i.red - meas_i.red);
    diff_g = (meas_i.green >= entry_i.green) ? (meas_i.green - entry_i.green)
                                             : (entry_i.green - meas_i.green);
    diff_b = (meas_i.blue >= entry_i.blue) ? (meas_i.blue - entry_i.blue)
                                           : (entry_i.blue - meas_i.blue);
    match_o = (diff_r <= tol_i) && (diff_g <= tol_i) && (diff_b <= tol_i);
  end

endmodule

FILE: rtl/rgb_tolerance_match_table.sv
// Top level of the RGB tolerance match table.
// Input items arrive on req_i and each gives exactly one result beat on rsp_o.
// A register item (action 1) appends its colour to the table and answers
// "registered" with the new index, or "table full" once every entry is used.
// An identify item (action 0) walks the stored entries from index 0 through a
// single tolerance compare unit, one entry per cycle as the table RAM read
// port delivers it, and answers the first matching index or "unidentified".
// A register item moves its result through the result register into the output
// register on rsp_o. An identify item ends at the first matching entry, or after
// the last stored entry when none matches; on an empty table it skips the scan.
// The block takes one item at a time: req_i.ready is high only between items.
// The next item can be accepted in the cycle after the result is loaded.
// The result sits in an output register; the next item is accepted while it
// waits, but a new result is held back until the receiver takes the previous
// beat, so a stall on rsp_o stretches the item without losing anything.
// The tolerance register is written over the APB port at byte address 0.
// Reset empties the table and sets the tolerance to 10; no clearing pass runs.
module rgb_tolerance_match_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rtm_req_if.sink                           req_i,
  rtm_rsp_if.source                         rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rtm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rtm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rtm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e                          state_q, state_d;
  rtm_pkg::rgb_t                   meas_q, meas_d;
  logic [rtm_pkg::CNT_W-1:0]       count_q, count_d;
  logic [rtm_pkg::CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic [rtm_pkg::CNT_W-1:0]       cmp_idx_q, cmp_idx_d;
  logic                            cmp_vld_q, cmp_vld_d;
  rtm_pkg::status_e                res_status_q, res_status_d;
  logic [rtm_pkg::IDX_W-1:0]       res_idx_q, res_idx_d;
  logic                            out_valid_q, out_valid_d;
  rtm_pkg::status_e                out_status_q, out_status_d;
  logic [rtm_pkg::OUT_IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [rtm_pkg::CHAN_W-1:0]      tol_q, tol_d;

  logic                            req_fire;
  logic                            full;
  logic                            rd_issue;
  logic                            ram_we;
  logic                            cfg_sel;
  logic                            match;
  rtm_pkg::rgb_t                   req_rgb;
  rtm_pkg::rgb_t                   entry_rgb;

  assign req_rgb  = '{red: req_i.red, green: req_i.green, blue: req_i.blue};
  assign req_fire = req_i.valid && (state_q == ST_IDLE);
  assign full     = (count_q == rtm_pkg::CNT_W'(rtm_pkg::TABLE_DEPTH));
  assign rd_issue = (state_q == ST_SCAN) && (rd_idx_q < count_q);
  assign ram_we   = req_fire && req_i.action && !full;

  rtm_ram #(
    .WIDTH ($bits(rtm_pkg::rgb_t)),
    .DEPTH (rtm_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[rtm_pkg::IDX_W-1:0]),
    .wdata_i (req_rgb),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[rtm_pkg::IDX_W-1:0]),
    .rdata_o (entry_rgb)
  );

  rtm_match u_match (
    .meas_i  (meas_q),
    .entry_i (entry_rgb),
    .tol_i   (tol_q),
    .match_o (match)
  );

  // Configuration port: writes are taken in the access phase, pready stays high.
  assign cfg_sel = (paddr[rtm_pkg::APB_ADDR_W-1:2] == rtm_pkg::REG_TOLERANCE);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? rtm_pkg::APB_DATA_W'(tol_q) : '0;

  always_comb begin
    state_d      = state_q;
    meas_d       = meas_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = 1'b0;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    tol_d        = tol_q;

    if (psel && penable && pwrite && cfg_sel) begin
      tol_d = pwdata[rtm_pkg::CHAN_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          meas_d = req_rgb;
          if (req_i.action) begin
            if (full) begin
              res_status_d = rtm_pkg::STATUS_FULL;
              res_idx_d    = '0;
            end else begin
              res_status_d = rtm_pkg::STATUS_REGISTERED;
              res_idx_d    = count_q[rtm_pkg::IDX_W-1:0];
              count_d      = count_q + rtm_pkg::CNT_W'(1);
            end
            state_d = ST_RESULT;
          end else if (count_q == '0) begin
            res_status_d = rtm_pkg::STATUS_UNIDENTIFIED;
            res_idx_d    = '0;
            state_d      = ST_RESULT;
          end else begin
            rd_idx_d = '0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Reads run one entry ahead of the compare of the registered RAM data.
        if (rd_issue) begin
          rd_idx_d = rd_idx_q + rtm_pkg::CNT_W'(1);
        end
        cmp_vld_d = rd_issue;
        cmp_idx_d = rd_idx_q;
        if (cmp_vld_q) begin
          if (match) begin
            res_status_d = rtm_pkg::STATUS_IDENTIFIED;
            res_idx_d    = cmp_idx_q[rtm_pkg::IDX_W-1:0];
            cmp_vld_d    = 1'b0;
            state_d      = ST_RESULT;
          end else if ((cmp_idx_q + rtm_pkg::CNT_W'(1)) == count_q) begin
            res_status_d = rtm_pkg::STATUS_UNIDENTIFIED;
            res_idx_d    = '0;
            cmp_vld_d    = 1'b0;
            state_d      = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = rtm_pkg::OUT_IDX_W'(res_idx_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      meas_q       <= '0;
      count_q      <= '0;
      rd_idx_q     <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      res_status_q <= rtm_pkg::STATUS_IDENTIFIED;
      res_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= rtm_pkg::STATUS_IDENTIFIED;
      out_idx_q    <= '0;
      tol_q        <= rtm_pkg::TOL_RESET;
    end else begin
      state_q      <= state_d;
      meas_q       <= meas_d;
      count_q      <= count_d;
      rd_idx_q     <= rd_idx_d;
      cmp_idx_q    <= cmp_idx_d;
      cmp_vld_q    <= cmp_vld_d;
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_idx_q    <= out_idx_d;
      tol_q        <= tol_d;
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_index = out_idx_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rtm_pkg::CNT_W'(rtm_pkg::TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.action && !full) |=> (count_q == $past(count_q) + rtm_pkg::CNT_W'(1)))
    else $error("register item did not advance the entry count");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (cmp_idx_q < count_q))
    else $error("compare of an entry that was never written");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q != '0))
    else $error("scan started on an empty table");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_status_q == rtm_pkg::STATUS_UNIDENTIFIED) ||
                     (out_status_q == rtm_pkg::STATUS_FULL))) |-> (out_idx_q == '0))
    else $error("nonzero index on an unidentified or full result");
`endif

endmodule
